/* src/vrc_pkg.sv */
`timescale 1ns / 1ps

package vrc_pkg;

  // Access kind carried by each input item
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Upper address nibbles of the decoded pages
  localparam logic [3:0] PageLatch = 4'h6;
  localparam logic [3:0] PagePrg0  = 4'h8;
  localparam logic [3:0] PageMisc  = 4'h9;
  localparam logic [3:0] PagePrg1  = 4'hA;
  localparam logic [3:0] PageChrLo = 4'hB;
  localparam logic [3:0] PageChrHi = 4'hE;
  localparam logic [3:0] PageIrq   = 4'hF;

  // Register select codes after address-line routing
  localparam logic [1:0] SelIrqReloadLo = 2'd0;
  localparam logic [1:0] SelIrqReloadHi = 2'd1;
  localparam logic [1:0] SelIrqControl  = 2'd2;
  localparam logic [1:0] SelIrqAck      = 2'd3;
  localparam logic [1:0] SelMirror      = 2'd0;
  localparam logic [1:0] SelRamSwap     = 2'd2;

  // CHR slot offset: B000 page with select high bit clear is slot 0
  localparam logic [4:0] ChrSlotBase = 5'(8'hB << 1);

  // IRQ prescaler: 341 PPU dots per scanline, 3 dots per CPU access
  localparam logic signed [9:0] PrescaleReload = 10'sd341;
  localparam logic signed [9:0] PrescaleStep   = 10'sd3;

  // Per-variant board wiring
  typedef struct packed {
    logic       vrc4;
    logic       swapped;
    logic [2:0] sh1;
    logic [2:0] sh2;
    logic       is2a;
    logic       is2c;
  } variant_t;

  // IRQ register writes decoded in the top level
  typedef struct packed {
    logic       reload_lo;
    logic       reload_hi;
    logic       control;
    logic       ack;
    logic [3:0] data;
  } irq_wr_t;

  // Wiring table; codes above the last variant act as the last one
  function automatic variant_t variant_lookup(input logic [3:0] code);
    variant_t v;
    v = '0;
    case (code)
      4'd0:    v = '{1'b0, 1'b1, 3'd0, 3'd0, 1'b1, 1'b0};
      4'd1:    v = '{1'b0, 1'b0, 3'd0, 3'd0, 1'b0, 1'b0};
      4'd2:    v = '{1'b0, 1'b1, 3'd0, 3'd0, 1'b0, 1'b1};
      4'd3:    v = '{1'b1, 1'b0, 3'd1, 3'd0, 1'b0, 1'b0};
      4'd4:    v = '{1'b1, 1'b1, 3'd0, 3'd0, 1'b0, 1'b0};
      4'd5:    v = '{1'b1, 1'b0, 3'd6, 3'd0, 1'b0, 1'b0};
      4'd6:    v = '{1'b1, 1'b1, 3'd2, 3'd0, 1'b0, 1'b0};
      4'd7:    v = '{1'b1, 1'b0, 3'd2, 3'd0, 1'b0, 1'b0};
      4'd8:    v = '{1'b1, 1'b0, 3'd0, 3'd0, 1'b0, 1'b0};
      4'd9:    v = '{1'b1, 1'b0, 3'd1, 3'd6, 1'b0, 1'b0};
      4'd10:   v = '{1'b1, 1'b0, 3'd0, 3'd2, 1'b0, 1'b0};
      default: v = '{1'b1, 1'b1, 3'd0, 3'd2, 1'b0, 1'b0};
    endcase
    return v;
  endfunction

endpackage

/* src/vrc_if.sv */
`timescale 1ns / 1ps

// CPU access channel
interface vrc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] address;
  logic [7:0]  bus_data;

  modport source (output valid, opcode, address, bus_data, input ready);
  modport sink   (input valid, opcode, address, bus_data, output ready);
endinterface

// Mapper state channel, one item per access
interface vrc_out_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [1:0] mirroring;
  logic       prg_ram_enable;
  logic [4:0] prg_bank_switchable;
  logic [4:0] prg_bank_middle;
  logic       prg_swap;
  logic       chr_update;
  logic [2:0] chr_slot;
  logic [8:0] chr_bank;
  logic       read_hit;
  logic [7:0] read_data;

  modport source (output valid, irq_line, mirroring, prg_ram_enable, prg_bank_switchable,
                  prg_bank_middle, prg_swap, chr_update, chr_slot, chr_bank, read_hit,
                  read_data, input ready);
  modport sink   (input valid, irq_line, mirroring, prg_ram_enable, prg_bank_switchable,
                  prg_bank_middle, prg_swap, chr_update, chr_slot, chr_bank, read_hit,
                  read_data, output ready);
endinterface

// Variant select write channel
interface vrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/vrc_irq.sv */
`timescale 1ns / 1ps

module vrc_irq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            vrc4,
  input  vrc_pkg::irq_wr_t wr,
  output logic            irq_line_nxt
);
  import vrc_pkg::*;

  logic [7:0]        reload_r, reload_nxt;
  logic              mode_r, mode_nxt;
  logic              en_r, en_nxt;
  logic              en_ack_r, en_ack_nxt;
  logic [7:0]        count_r, count_nxt;
  logic signed [9:0] pre_r, pre_nxt;
  logic              pend_r, pend_nxt;

  logic signed [9:0] pre_dec;
  logic              expired;

  // Register writes first, then the tick on the written values
  always_comb begin
    reload_nxt = reload_r;
    mode_nxt   = mode_r;
    en_nxt     = en_r;
    en_ack_nxt = en_ack_r;
    count_nxt  = count_r;
    pre_nxt    = pre_r;
    pend_nxt   = pend_r;

    if (wr.reload_lo) begin
      reload_nxt[3:0] = wr.data;
    end
    if (wr.reload_hi) begin
      reload_nxt[7:4] = wr.data;
    end
    if (wr.control) begin
      pend_nxt   = 1'b0;
      mode_nxt   = wr.data[2];
      en_nxt     = wr.data[1];
      en_ack_nxt = wr.data[0];
      if (wr.data[1]) begin
        count_nxt = reload_r;
        pre_nxt   = PrescaleReload;
      end
    end
    if (wr.ack) begin
      pend_nxt = 1'b0;
      en_nxt   = en_ack_r;
    end

    // Prescaler and counter tick
    pre_dec = pre_nxt - PrescaleStep;
    expired = pre_dec[9] || (pre_dec == '0);
    if (vrc4 && en_nxt) begin
      if (mode_nxt || expired) begin
        if (count_nxt == 8'hFF) begin
          pend_nxt  = 1'b1;
          count_nxt = reload_nxt;
        end else begin
          count_nxt = count_nxt + 8'd1;
        end
      end
      pre_nxt = expired ? PrescaleReload : pre_dec;
    end
  end

  assign irq_line_nxt = pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= '0;
      mode_r   <= 1'b0;
      en_r     <= 1'b0;
      en_ack_r <= 1'b0;
      count_r  <= '0;
      pre_r    <= PrescaleReload;
      pend_r   <= 1'b0;
    end else if (step) begin
      reload_r <= reload_nxt;
      mode_r   <= mode_nxt;
      en_r     <= en_nxt;
      en_ack_r <= en_ack_nxt;
      count_r  <= count_nxt;
      pre_r    <= pre_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

/* src/vrc2_vrc4_bank_mapper_with_irq.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    opcode, address, bus_data (one CPU access)
// out_ch    out  valid/ready    irq_line .. read_data (mapper state after the access)
// cfg_ch    in   valid/ready    data: variant select, 4 bits
//
// One access per cycle sustained while the result side keeps taking items; an access
// waits in the input register, then decode, bank and IRQ update into the result register.
// Synchronous active-low reset clears all mapper state; the prescaler loads 341.
// A stalled result holds the result register; the input register keeps taking an item
// whenever the result moves on the same edge.

module vrc2_vrc4_bank_mapper_with_irq (
  input  logic clk,
  input  logic rst_n,
  vrc_in_if.sink    in_ch,
  vrc_out_if.source out_ch,
  vrc_cfg_if.sink   cfg_ch
);
  import vrc_pkg::*;

  // Input register
  logic        s0_valid_r;
  logic        s0_op_r;
  logic [15:0] s0_addr_r;
  logic [7:0]  s0_data_r;
  logic        advance;

  // Variant select
  logic [3:0] variant_r;
  variant_t   v;

  // Mapper state
  logic [4:0] prg0_r, prg0_nxt;
  logic [4:0] prg1_r, prg1_nxt;
  logic       swap_r, swap_nxt;
  logic [1:0] mirror_r, mirror_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic       latch_r, latch_nxt;
  logic [8:0] chr_regs_r [8];

  // Decode
  logic       is_write;
  logic [3:0] page;
  logic [1:0] sel_a;
  logic [1:0] sel_b;
  logic [1:0] sel;
  logic [4:0] slot_full;
  logic [2:0] slot;
  logic       chr_wr;
  logic [8:0] chr_old;
  logic [8:0] chr_new;
  logic [8:0] chr_eff;
  logic       hit;
  irq_wr_t    irq_wr;
  logic       irq_line_nxt;

  // Result register
  logic       out_valid_r;
  logic       irq_line_r;
  logic [1:0] mirror_out_r;
  logic       ram_en_out_r;
  logic [4:0] prg0_out_r;
  logic [4:0] prg1_out_r;
  logic       swap_out_r;
  logic       chr_upd_r;
  logic [2:0] chr_slot_r;
  logic [8:0] chr_bank_r;
  logic       hit_r;
  logic [7:0] rdata_r;

  // Handshake: input register moves on whenever the result register is free
  assign advance     = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s0_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_op_r   <= in_ch.opcode;
      s0_addr_r <= in_ch.address;
      s0_data_r <= in_ch.bus_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= '0;
    end else if (cfg_ch.valid) begin
      variant_r <= cfg_ch.data;
    end
  end

  assign v = variant_lookup(variant_r);

  // Address-line routing to the register select
  always_comb begin
    sel_a = 2'(s0_addr_r >> v.sh1);
    sel_b = (v.sh2 != '0) ? 2'(s0_addr_r >> v.sh2) : 2'b00;
    sel   = v.swapped ? {(sel_a[0] | sel_b[0]), (sel_a[1] | sel_b[1])} : (sel_a | sel_b);
  end

  assign is_write  = (op_t'(s0_op_r) == OP_WRITE);
  assign page      = s0_addr_r[15:12];
  assign slot_full = {page, sel[1]} - ChrSlotBase;
  assign slot      = slot_full[2:0];
  assign chr_wr    = is_write && (page >= PageChrLo) && (page <= PageChrHi);
  assign chr_old   = chr_regs_r[slot];
  assign chr_new   = sel[0] ? {s0_data_r[4:0], chr_old[3:0]} : {chr_old[8:4], s0_data_r[3:0]};

  // Effective 1K bank seen by the PPU side
  always_comb begin
    if (v.is2a) begin
      chr_eff = {2'b00, chr_new[7:1]};
    end else if (v.vrc4) begin
      chr_eff = {1'b0, chr_new[7:0]};
    end else begin
      chr_eff = chr_new;
    end
  end

  // Register writes
  always_comb begin
    prg0_nxt   = prg0_r;
    prg1_nxt   = prg1_r;
    swap_nxt   = swap_r;
    mirror_nxt = mirror_r;
    ram_en_nxt = ram_en_r;
    latch_nxt  = latch_r;
    irq_wr     = '0;
    irq_wr.data = s0_data_r[3:0];
    if (is_write) begin
      if (page == PageLatch) begin
        latch_nxt = s0_data_r[0];
      end
      case (page)
        PagePrg0: begin
          prg0_nxt = s0_data_r[4:0];
        end
        PagePrg1: begin
          prg1_nxt = s0_data_r[4:0];
        end
        PageMisc: begin
          if (v.vrc4) begin
            if (sel == SelRamSwap) begin
              ram_en_nxt = s0_data_r[0];
              swap_nxt   = s0_data_r[1];
            end else if (sel == SelMirror) begin
              mirror_nxt = s0_data_r[1:0];
            end
          end else begin
            mirror_nxt = {1'b0, s0_data_r[0]};
          end
        end
        PageIrq: begin
          irq_wr.reload_lo = (sel == SelIrqReloadLo);
          irq_wr.reload_hi = (sel == SelIrqReloadHi);
          irq_wr.control   = (sel == SelIrqControl);
          irq_wr.ack       = (sel == SelIrqAck);
        end
        default: begin
        end
      endcase
    end
  end

  // Latch readback on VRC2a/b only
  assign hit = !is_write && !v.vrc4 && !v.is2c && (page == PageLatch);

  vrc_irq u_irq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .vrc4         (v.vrc4),
    .wr           (irq_wr),
    .irq_line_nxt (irq_line_nxt)
  );

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg0_r   <= '0;
      prg1_r   <= '0;
      swap_r   <= 1'b0;
      mirror_r <= '0;
      ram_en_r <= 1'b0;
      latch_r  <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chr_regs_r[i] <= '0;
      end
    end else if (advance) begin
      prg0_r   <= prg0_nxt;
      prg1_r   <= prg1_nxt;
      swap_r   <= swap_nxt;
      mirror_r <= mirror_nxt;
      ram_en_r <= ram_en_nxt;
      latch_r  <= latch_nxt;
      if (chr_wr) begin
        chr_regs_r[slot] <= chr_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_line_r   <= irq_line_nxt;
      mirror_out_r <= mirror_nxt;
      ram_en_out_r <= v.is2c ? 1'b1 : (v.vrc4 && ram_en_nxt);
      prg0_out_r   <= prg0_nxt;
      prg1_out_r   <= prg1_nxt;
      swap_out_r   <= swap_nxt;
      chr_upd_r    <= chr_wr;
      chr_slot_r   <= chr_wr ? slot : 3'd0;
      chr_bank_r   <= chr_wr ? chr_eff : 9'd0;
      hit_r        <= hit;
      rdata_r      <= hit ? {s0_data_r[7:1], latch_r} : 8'd0;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.irq_line            = irq_line_r;
  assign out_ch.mirroring           = mirror_out_r;
  assign out_ch.prg_ram_enable      = ram_en_out_r;
  assign out_ch.prg_bank_switchable = prg0_out_r;
  assign out_ch.prg_bank_middle     = prg1_out_r;
  assign out_ch.prg_swap            = swap_out_r;
  assign out_ch.chr_update          = chr_upd_r;
  assign out_ch.chr_slot            = chr_slot_r;
  assign out_ch.chr_bank            = chr_bank_r;
  assign out_ch.read_hit            = hit_r;
  assign out_ch.read_data           = rdata_r;

endmodule

/* sim/vrc_mapper_monitor.sv */
`timescale 1ns / 1ps

// Watches the access, result and variant channels, keeps a shadow copy of the
// mapper state and compares every result item with the predicted mapper view.
module vrc_mapper_monitor (
  input  logic clk,
  input  logic rst_n,
  vrc_in_if    in_ch,
  vrc_out_if   out_ch,
  vrc_cfg_if   cfg_ch,
  output int   error_count,
  output int   outstanding
);
  import vrc_pkg::*;

  // Mapper view after one access, field for field as on the result channel
  typedef struct packed {
    logic       irq_line;
    logic [1:0] mirroring;
    logic       prg_ram_enable;
    logic [4:0] prg_bank_switchable;
    logic [4:0] prg_bank_middle;
    logic       prg_swap;
    logic       chr_update;
    logic [2:0] chr_slot;
    logic [8:0] chr_bank;
    logic       read_hit;
    logic [7:0] read_data;
  } mapper_view_t;

  mapper_view_t expected_views[$];

  // Shadow mapper state
  logic [3:0] variant_code;
  logic [4:0] prg_first;
  logic [4:0] prg_second;
  logic       prg_swap_bit;
  logic [8:0] chr_regs [8];
  logic [1:0] mirror_mode;
  logic       ram_enable;
  logic       latch_bit;
  logic [7:0] irq_reload;
  logic [7:0] irq_count;
  logic       irq_cycle_mode;
  logic       irq_enabled;
  logic       irq_enable_after_ack;
  logic       irq_pending;
  int         prescale;

  // Board wiring per variant code; codes past the last variant wire as the last
  function automatic variant_t wiring_of(input logic [3:0] code);
    variant_t w;
    w         = '0;
    w.vrc4    = (code >= 4'd3);
    w.is2a    = (code == 4'd0);
    w.is2c    = (code == 4'd2);
    w.swapped = (code == 4'd0) || (code == 4'd2) || (code == 4'd4) || (code == 4'd6) ||
                (code >= 4'd11);
    case (code)
      4'd3, 4'd9: w.sh1 = 3'd1;
      4'd5:       w.sh1 = 3'd6;
      4'd6, 4'd7: w.sh1 = 3'd2;
      default:    w.sh1 = 3'd0;
    endcase
    if (code == 4'd9)
      w.sh2 = 3'd6;
    else if (code >= 4'd10)
      w.sh2 = 3'd2;
    return w;
  endfunction

  // One prescaler/counter step of the VRC4 IRQ unit
  function automatic void irq_clock();
    if (!irq_enabled)
      return;
    prescale -= int'(PrescaleStep);
    if (irq_cycle_mode || prescale <= 0) begin
      if (irq_count == 8'hFF) begin
        irq_pending = 1'b1;
        irq_count   = irq_reload;
      end else begin
        irq_count = irq_count + 8'd1;
      end
      if (prescale <= 0)
        prescale = int'(PrescaleReload);
    end
  endfunction

  // Apply one CPU access to the shadow state and return the mapper view
  function automatic mapper_view_t predict_access(input op_t op, input logic [15:0] addr,
                                                  input logic [7:0] data);
    variant_t     w;
    mapper_view_t v;
    logic [1:0]   sel;
    logic [2:0]   slot;
    logic [8:0]   bank_reg;
    logic [3:0]   page;
    w    = wiring_of(variant_code);
    v    = '0;
    page = addr[15:12];
    if (op == OP_READ) begin
      if (w.vrc4)
        irq_clock();
      // latch readback exists on VRC2a/b only
      if (!w.vrc4 && !w.is2c && page == PageLatch) begin
        v.read_hit  = 1'b1;
        v.read_data = {data[7:1], latch_bit};
      end
    end else begin
      if (page == PageLatch)
        latch_bit = data[0];
      sel = 2'(addr >> w.sh1);
      if (w.sh2 != 3'd0)
        sel = sel | 2'(addr >> w.sh2);
      if (w.swapped)
        sel = {sel[0], sel[1]};
      case (page)
        PagePrg0: prg_first = data[4:0];
        PagePrg1: prg_second = data[4:0];
        PageMisc: begin
          if (w.vrc4) begin
            if (sel == SelRamSwap) begin
              ram_enable   = data[0];
              prg_swap_bit = data[1];
            end else if (sel == SelMirror) begin
              mirror_mode = data[1:0];
            end
          end else begin
            mirror_mode = {1'b0, data[0]};
          end
        end
        PageIrq: begin
          case (sel)
            SelIrqReloadLo: irq_reload[3:0] = data[3:0];
            SelIrqReloadHi: irq_reload[7:4] = data[3:0];
            SelIrqControl: begin
              irq_pending          = 1'b0;
              irq_cycle_mode       = data[2];
              irq_enabled          = data[1];
              irq_enable_after_ack = data[0];
              if (irq_enabled) begin
                irq_count = irq_reload;
                prescale  = int'(PrescaleReload);
              end
            end
            SelIrqAck: begin
              irq_pending = 1'b0;
              irq_enabled = irq_enable_after_ack;
            end
            default: begin
            end
          endcase
        end
        default: begin
          // CHR pages B000-EFFF: one nibble or the high five bits of a slot
          if (page >= PageChrLo && page <= PageChrHi) begin
            slot     = 3'({page, sel[1]} - ChrSlotBase);
            bank_reg = chr_regs[slot];
            if (sel[0])
              bank_reg[8:4] = data[4:0];
            else
              bank_reg[3:0] = data[3:0];
            chr_regs[slot] = bank_reg;
            v.chr_update   = 1'b1;
            v.chr_slot     = slot;
            if (w.is2a)
              v.chr_bank = {2'b00, bank_reg[7:1]};
            else if (w.vrc4)
              v.chr_bank = {1'b0, bank_reg[7:0]};
            else
              v.chr_bank = bank_reg;
          end
        end
      endcase
      if (w.vrc4)
        irq_clock();
    end
    v.irq_line            = irq_pending;
    v.mirroring           = mirror_mode;
    v.prg_ram_enable      = w.is2c ? 1'b1 : (w.vrc4 ? ram_enable : 1'b0);
    v.prg_bank_switchable = prg_first;
    v.prg_bank_middle     = prg_second;
    v.prg_swap            = prg_swap_bit;
    return v;
  endfunction

  function automatic void check_field(input string field, input logic [8:0] exp_v,
                                      input logic [8:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Shadow state update, result comparison, then prediction of the new item
  always @(posedge clk) begin
    mapper_view_t exp_v;
    if (!rst_n) begin
      variant_code         = 4'd0;
      prg_first            = '0;
      prg_second           = '0;
      prg_swap_bit         = 1'b0;
      for (int i = 0; i < 8; i++)
        chr_regs[i] = '0;
      mirror_mode          = '0;
      ram_enable           = 1'b0;
      latch_bit            = 1'b0;
      irq_reload           = '0;
      irq_count            = '0;
      irq_cycle_mode       = 1'b0;
      irq_enabled          = 1'b0;
      irq_enable_after_ack = 1'b0;
      irq_pending          = 1'b0;
      prescale             = int'(PrescaleReload);
      expected_views.delete();
      error_count          = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready)
        variant_code = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_views.size() == 0) begin
          $error("result item with no access waiting for it");
          error_count++;
        end else begin
          exp_v = expected_views.pop_front();
          check_field("irq_line", 9'(exp_v.irq_line), 9'(out_ch.irq_line));
          check_field("mirroring", 9'(exp_v.mirroring), 9'(out_ch.mirroring));
          check_field("prg_ram_enable", 9'(exp_v.prg_ram_enable),
                      9'(out_ch.prg_ram_enable));
          check_field("prg_bank_switchable", 9'(exp_v.prg_bank_switchable),
                      9'(out_ch.prg_bank_switchable));
          check_field("prg_bank_middle", 9'(exp_v.prg_bank_middle),
                      9'(out_ch.prg_bank_middle));
          check_field("prg_swap", 9'(exp_v.prg_swap), 9'(out_ch.prg_swap));
          check_field("chr_update", 9'(exp_v.chr_update), 9'(out_ch.chr_update));
          check_field("chr_slot", 9'(exp_v.chr_slot), 9'(out_ch.chr_slot));
          check_field("chr_bank", exp_v.chr_bank, out_ch.chr_bank);
          check_field("read_hit", 9'(exp_v.read_hit), 9'(out_ch.read_hit));
          check_field("read_data", 9'(exp_v.read_data), 9'(out_ch.read_data));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_views.push_back(predict_access(op_t'(in_ch.opcode), in_ch.address,
                                                in_ch.bus_data));
    end
    outstanding = expected_views.size();
  end

endmodule

/* sim/tb_vrc2_vrc4_bank_mapper_with_irq.sv */
`timescale 1ns / 1ps

module tb_vrc2_vrc4_bank_mapper_with_irq;
  import vrc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vrc_in_if  in_ch ();
  vrc_out_if out_ch ();
  vrc_cfg_if cfg_ch ();

  int         error_count;
  int         outstanding;
  logic [3:0] cur_variant = 4'd0;
  int         burst_left = 0;
  bit         hold_off_req = 1'b0;

  vrc2_vrc4_bank_mapper_with_irq dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vrc_mapper_monitor monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Sender gap: mostly none or short, a few long, with gap-free bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0)
      burst_left = $urandom_range(20, 50);
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Address that hits a register select on the current variant's wiring
  function automatic logic [15:0] reg_addr(input logic [3:0] page, input logic [1:0] sel);
    variant_t    w;
    logic [1:0]  raw;
    logic [15:0] a;
    w        = variant_lookup(cur_variant);
    raw      = w.swapped ? {sel[0], sel[1]} : sel;
    a        = {page, 12'h000} | (16'(raw) << w.sh1);
    // lines 11:8 and 5:4 feed no select on any board
    a[11:8]  = 4'($urandom);
    a[5:4]   = 2'($urandom);
    return a;
  endfunction

  task automatic send_access(input op_t op, input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.address  <= addr;
    in_ch.bus_data <= data;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering items and let every expected result drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_variant(input logic [3:0] code);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_variant = code;
  endtask

  // Reload, then control with the enable set most of the time
  task automatic irq_setup(input bit cycle_mode, input logic [7:0] reload);
    send_access(OP_WRITE, reg_addr(PageIrq, SelIrqReloadLo), {4'($urandom), reload[3:0]});
    send_access(OP_WRITE, reg_addr(PageIrq, SelIrqReloadHi), {4'($urandom), reload[7:4]});
    send_access(OP_WRITE, reg_addr(PageIrq, SelIrqControl),
                {5'($urandom), cycle_mode, ($urandom_range(0, 7) != 0), 1'($urandom)});
  endtask

  task automatic random_access(input bit allow_ctrl);
    int          pick;
    logic [3:0]  page;
    logic [1:0]  sel;
    logic [15:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // reads: latch window, its borders, anywhere
      case ($urandom_range(0, 2))
        0: addr = {PageLatch, 12'($urandom)};
        1: begin
          case ($urandom_range(0, 3))
            0:       addr = 16'h5FFF;
            1:       addr = 16'h6000;
            2:       addr = 16'h6FFF;
            default: addr = 16'h7000;
          endcase
        end
        default: addr = 16'($urandom);
      endcase
      send_access(OP_READ, addr, 8'($urandom));
    end else if (pick < 32) begin
      send_access(OP_WRITE, 16'($urandom), 8'($urandom));
    end else if (pick < 37) begin
      send_access(OP_WRITE, {PageLatch, 12'($urandom)}, 8'($urandom));
    end else if (pick < 42) begin
      send_access(OP_WRITE, reg_addr(PageIrq, SelIrqAck), 8'($urandom));
    end else begin
      page = PagePrg0 + 4'($urandom_range(0, 7));
      sel  = 2'($urandom);
      // control writes restart the prescaler, keep them rare
      if (page == PageIrq && sel == SelIrqControl &&
          !(allow_ctrl && $urandom_range(0, 2) == 0))
        sel = SelIrqAck;
      send_access(OP_WRITE, reg_addr(page, sel), 8'($urandom));
    end
  endtask

  // Result side: steady or random stretches, rare long stalls, one long hold-off on request
  initial begin : result_sink
    bit steady;
    int seg_len;
    int hold_cnt;
    out_ch.ready = 1'b0;
    forever begin
      steady  = ($urandom_range(0, 3) == 0);
      seg_len = $urandom_range(8, 40);
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          out_ch.ready <= 1'b0;
          hold_cnt = 0;
          while (hold_cnt < 300) begin
            @(posedge clk);
            hold_cnt++;
          end
        end else if (steady) begin
          out_ch.ready <= 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(15, 40)) @(posedge clk);
        end else begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // Stimulus
  initial begin : access_source
    bit         long_phase;
    logic [7:0] reload;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_READ;
    in_ch.address  = '0;
    in_ch.bus_data = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // VRC2a: address extremes, latch window and its borders, PRG, mirroring, CHR and IRQ pages
    write_variant(4'd0);
    send_access(OP_READ, 16'h0000, 8'h00);
    send_access(OP_READ, 16'hFFFF, 8'hFF);
    send_access(OP_WRITE, 16'h6FFF, 8'h01);
    send_access(OP_READ, 16'h6000, 8'h00);
    send_access(OP_READ, 16'h6FFF, 8'hFE);
    send_access(OP_READ, 16'h7000, 8'hFF);
    send_access(OP_READ, 16'h5FFF, 8'hFF);
    send_access(OP_WRITE, 16'h6000, 8'hFE);
    send_access(OP_WRITE, 16'h8000, 8'hFF);
    send_access(OP_WRITE, 16'hA000, 8'hFF);
    send_access(OP_WRITE, 16'h9000, 8'hFF);
    send_access(OP_WRITE, 16'hB000, 8'hFF);
    send_access(OP_WRITE, 16'hE003, 8'hFF);
    send_access(OP_WRITE, 16'hF003, 8'hFF);

    // VRC4f: RAM enable and swap, ignored 9001/9003, IRQ overflow and acknowledge
    write_variant(4'd8);
    send_access(OP_WRITE, 16'h9002, 8'h03);
    send_access(OP_WRITE, 16'h9001, 8'hFF);
    send_access(OP_WRITE, 16'h9003, 8'hFF);
    send_access(OP_WRITE, 16'h9000, 8'h03);
    send_access(OP_WRITE, 16'hF000, 8'h0F);
    send_access(OP_WRITE, 16'hF001, 8'h0F);
    send_access(OP_WRITE, 16'hF002, 8'h07);
    send_access(OP_READ, 16'h6000, 8'h55);
    send_access(OP_WRITE, 16'hF003, 8'h00);
    send_access(OP_WRITE, 16'hE002, 8'hFF);
    send_access(OP_WRITE, 16'hF002, 8'h00);

    // Random phases over every variant code plus two out-of-range codes;
    // VRC4f runs long in scanline mode so the prescaler wraps
    for (int p = 0; p < 14; p++) begin
      write_variant((p < 13) ? 4'(p) : 4'd15);
      long_phase = (p == 8);
      if (long_phase)
        reload = 8'hFF;
      else if ($urandom_range(0, 1) == 0)
        reload = 8'($urandom_range(8'hF0, 8'hFF));
      else
        reload = 8'($urandom);
      irq_setup(long_phase ? 1'b0 : 1'($urandom), reload);
      for (int n = 0; n < (long_phase ? 260 : 33); n++) begin
        if (long_phase && n == 40)
          hold_off_req = 1'b1;
        random_access(!long_phase);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* files.f */
src/vrc_pkg.sv
src/vrc_if.sv
src/vrc_irq.sv
src/vrc2_vrc4_bank_mapper_with_irq.sv
sim/vrc_mapper_monitor.sv
sim/tb_vrc2_vrc4_bank_mapper_with_irq.sv
